// ===== sv/slps_pkg.sv =====
// shared types and constants for the status led pattern sequencer
// no dependencies; imported by every module of the block
package slps_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned MS_W       = 16;
    localparam int unsigned DUTY_W     = 8;

    typedef enum logic [1:0] {
        MODE_OFF       = 2'd0,
        MODE_SEARCHING = 2'd1,
        MODE_SENDING   = 2'd2,
        MODE_CONNECTED = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INVERT_DUTY    = 3'd0,
        REG_CHANNEL_ENABLE = 3'd1,
        REG_SLOW_HALF      = 3'd2,
        REG_FAST_HALF      = 3'd3,
        REG_PULSE_LENGTH   = 3'd4
    } t_reg_idx;

    localparam logic [DUTY_W-1:0] DUTY_FULL  = 8'd255;
    localparam logic [DUTY_W-1:0] DUTY_AMBER = 8'd64;
    localparam logic [DUTY_W-1:0] DUTY_DARK  = 8'd0;

    localparam logic [MS_W-1:0] RST_SLOW_MS  = 16'd300;
    localparam logic [MS_W-1:0] RST_FAST_MS  = 16'd80;
    localparam logic [MS_W-1:0] RST_PULSE_MS = 16'd3000;
    localparam logic [2:0]      RST_CH_EN    = 3'd7;

    typedef struct packed {
        logic            invert_duty;
        logic [2:0]      channel_enable;
        logic [MS_W-1:0] slow_half_ms;
        logic [MS_W-1:0] fast_half_ms;
        logic [MS_W-1:0] pulse_ms;
    } t_cfg;

    typedef struct packed {
        logic              updated;
        logic              red_write;
        logic              green_write;
        logic              blue_write;
        logic [DUTY_W-1:0] red_duty;
        logic [DUTY_W-1:0] green_duty;
        logic [DUTY_W-1:0] blue_duty;
    } t_result;

endpackage

// ===== sv/slps_cfg.sv =====
// configuration register file of the status led pattern sequencer
// depends on slps_pkg
module slps_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [slps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [slps_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output slps_pkg::t_cfg                  o_cfg
);
    import slps_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.invert_duty    <= 1'b0;
            r_cfg.channel_enable <= RST_CH_EN;
            r_cfg.slow_half_ms   <= RST_SLOW_MS;
            r_cfg.fast_half_ms   <= RST_FAST_MS;
            r_cfg.pulse_ms       <= RST_PULSE_MS;
        end else if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_index))
                REG_INVERT_DUTY:    r_cfg.invert_duty    <= i_cfg_wdata[0];
                REG_CHANNEL_ENABLE: r_cfg.channel_enable <= i_cfg_wdata[2:0];
                REG_SLOW_HALF:      r_cfg.slow_half_ms   <= i_cfg_wdata[MS_W-1:0];
                REG_FAST_HALF:      r_cfg.fast_half_ms   <= i_cfg_wdata[MS_W-1:0];
                REG_PULSE_LENGTH:   r_cfg.pulse_ms       <= i_cfg_wdata[MS_W-1:0];
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/slps_core.sv =====
// pattern state and combinational evaluation of one item
// depends on slps_pkg
module slps_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic              i_cmd,
    input  logic [1:0]        i_new_mode,
    input  slps_pkg::t_cfg    i_cfg,
    output slps_pkg::t_result o_result
);
    import slps_pkg::*;

    t_mode             r_req_mode, n_req_mode;
    t_mode             r_shown_mode, n_shown_mode;
    logic              r_phase, n_phase;
    logic [MS_W-1:0]   r_remaining_ms, n_remaining_ms;
    logic              r_hold, n_hold;
    logic [DUTY_W-1:0] r_red, n_red;
    logic [DUTY_W-1:0] r_green, n_green;
    logic [DUTY_W-1:0] r_blue, n_blue;

    logic              eval;
    t_mode             st;
    logic              timed;
    logic [MS_W-1:0]   wait_ms;
    logic [DUTY_W-1:0] d_r, d_g, d_b;
    logic [DUTY_W-1:0] p_r, p_g, p_b;
    logic [2:0]        wr;

    always_comb begin
        st   = i_cmd ? t_mode'(i_new_mode) : r_req_mode;
        eval = i_cmd ? (t_mode'(i_new_mode) != r_req_mode)
                     : (!r_hold && (r_remaining_ms <= MS_W'(1)));

        n_phase = r_phase;
        d_r     = DUTY_DARK;
        d_g     = DUTY_DARK;
        d_b     = DUTY_DARK;
        timed   = 1'b0;
        wait_ms = i_cfg.pulse_ms;
        case (st)
            MODE_SEARCHING: begin
                n_phase = !r_phase;
                d_r     = n_phase ? DUTY_FULL : DUTY_DARK;
                d_g     = n_phase ? DUTY_AMBER : DUTY_DARK;
                timed   = 1'b1;
                wait_ms = i_cfg.slow_half_ms;
            end
            MODE_SENDING: begin
                n_phase = !r_phase;
                d_b     = n_phase ? DUTY_FULL : DUTY_DARK;
                timed   = 1'b1;
                wait_ms = i_cfg.fast_half_ms;
            end
            MODE_CONNECTED: begin
                // fresh join only when not coming from connected or sending
                if (r_shown_mode != MODE_CONNECTED && r_shown_mode != MODE_SENDING) begin
                    d_g   = DUTY_FULL;
                    timed = 1'b1;
                end
            end
            default: ;
        endcase
        if (!eval) begin
            n_phase = r_phase;
        end

        // zero period behaves as one ms
        if (wait_ms == '0) begin
            wait_ms = MS_W'(1);
        end

        // inverted polarity: 255 - d is the bitwise complement
        p_r = i_cfg.invert_duty ? ~d_r : d_r;
        p_g = i_cfg.invert_duty ? ~d_g : d_g;
        p_b = i_cfg.invert_duty ? ~d_b : d_b;
        wr  = eval ? i_cfg.channel_enable : 3'b000;

        n_red   = wr[0] ? p_r : r_red;
        n_green = wr[1] ? p_g : r_green;
        n_blue  = wr[2] ? p_b : r_blue;

        n_req_mode   = st;
        n_shown_mode = eval ? st : r_shown_mode;
        if (eval) begin
            n_remaining_ms = timed ? wait_ms : '0;
            n_hold         = !timed;
        end else begin
            n_remaining_ms = (!i_cmd && !r_hold) ? r_remaining_ms - MS_W'(1) : r_remaining_ms;
            n_hold         = r_hold;
        end

        o_result.updated     = eval;
        o_result.red_write   = wr[0];
        o_result.green_write = wr[1];
        o_result.blue_write  = wr[2];
        o_result.red_duty    = n_red;
        o_result.green_duty  = n_green;
        o_result.blue_duty   = n_blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_mode     <= MODE_OFF;
            r_shown_mode   <= MODE_OFF;
            r_phase        <= 1'b0;
            r_remaining_ms <= '0;
            r_hold         <= 1'b1;
            r_red          <= DUTY_DARK;
            r_green        <= DUTY_DARK;
            r_blue         <= DUTY_DARK;
        end else if (i_fire) begin
            r_req_mode     <= n_req_mode;
            r_shown_mode   <= n_shown_mode;
            r_phase        <= n_phase;
            r_remaining_ms <= n_remaining_ms;
            r_hold         <= n_hold;
            r_red          <= n_red;
            r_green        <= n_green;
            r_blue         <= n_blue;
        end
    end

    // holding exactly when no countdown is pending
    a_hold_vs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold == (r_remaining_ms == '0))
        else $error("hold flag and countdown disagree");

    // every evaluation shows the requested mode, so the two never diverge
    a_shown_is_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shown_mode == r_req_mode)
        else $error("shown mode differs from requested mode");

    // a duty strobe needs an evaluation and an enabled channel
    a_strobe_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr != 3'b000) |-> (eval && ((wr & ~i_cfg.channel_enable) == 3'b000)))
        else $error("strobe without evaluation or on disabled channel");

    // a tick with a long wait only counts down
    a_tick_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !i_cmd && !r_hold && r_remaining_ms > MS_W'(1))
        |=> (r_remaining_ms == $past(r_remaining_ms) - MS_W'(1)))
        else $error("countdown did not step by one");

endmodule

// ===== sv/status_led_pattern_sequencer_top.sv =====
// top level of the rgb status led pattern sequencer
// depends on slps_pkg, slps_cfg and slps_core
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_cmd, i_new_mode
//  out     | output    | o_out_valid/i_out_stall | o_updated, o_*_write, o_*_duty
//  cfg     | input     | i_cfg_wr_en             | i_cfg_index, i_cfg_wdata
//
// one item per cycle sustained while the output is not stalled; an accepted item
// passes the input register, then evaluation into the result register
// every item gives exactly one result
// reset (synchronous, active low) clears both pipeline stages and restores the
// pattern state and register defaults; no clearing pass is needed
// a stall on the output holds the result register, then backs up into the input
// register, and only then raises o_in_stall
module status_led_pattern_sequencer_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_cmd,
    input  logic [1:0]                      i_new_mode,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_updated,
    output logic                            o_red_write,
    output logic                            o_green_write,
    output logic                            o_blue_write,
    output logic [slps_pkg::DUTY_W-1:0]     o_red_duty,
    output logic [slps_pkg::DUTY_W-1:0]     o_green_duty,
    output logic [slps_pkg::DUTY_W-1:0]     o_blue_duty,
    input  logic                            i_cfg_wr_en,
    input  logic [slps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [slps_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import slps_pkg::*;

    // input register stage
    logic       r_in_vld;
    logic       r_cmd;
    logic [1:0] r_new_mode;

    // result register stage
    logic       r_out_vld;
    t_result    r_result;

    t_cfg       cfg;
    t_result    core_result;
    logic       out_ready;   // result register can take a new item
    logic       advance;     // input stage item is evaluated this cycle
    logic       in_take;     // new item accepted from the input channel

    assign out_ready  = !r_out_vld || !i_out_stall;
    assign advance    = r_in_vld && out_ready;
    assign o_in_stall = r_in_vld && !out_ready;
    assign in_take    = i_in_valid && !o_in_stall;

    slps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // pattern state advances only when the item moves into the result register
    slps_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (advance),
        .i_cmd      (r_cmd),
        .i_new_mode (r_new_mode),
        .i_cfg      (cfg),
        .o_result   (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd      <= i_cmd;
            r_new_mode <= i_new_mode;
        end
        if (advance) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_updated     = r_result.updated;
    assign o_red_write   = r_result.red_write;
    assign o_green_write = r_result.green_write;
    assign o_blue_write  = r_result.blue_write;
    assign o_red_duty    = r_result.red_duty;
    assign o_green_duty  = r_result.green_duty;
    assign o_blue_duty   = r_result.blue_duty;

    // input stage never overwritten while its item waits
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !advance) |-> o_in_stall)
        else $error("input register would be overwritten");

    // a waiting result moves on only when taken
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |=> (r_out_vld && $stable(r_result)))
        else $error("stalled result lost or changed");

    // stall on the input only when both stages are full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && r_out_vld))
        else $error("input stalled with a free stage");

endmodule

// ===== bench/status_led_pattern_sequencer_top_tb.sv =====
// self-checking bench for status_led_pattern_sequencer_top: directed table, then random items
// depends on slps_pkg and the rtl of the block; uses an item-level pattern predictor as scoreboard
`timescale 1ns / 100ps

module status_led_pattern_sequencer_top_tb;
    import slps_pkg::*;

    // input item kinds
    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    // register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] REG_IDX_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IDX_SPARE_HI = 3'd7;

    // cycles with no handshake and no register write before the run is declared hung
    localparam int unsigned QUIET_LIMIT = 1000;
    // drain time after the last result
    localparam int unsigned TAIL_CYCLES = 8;

    typedef enum bit {
        ROW_ITEM,
        ROW_REG
    } t_row_kind;

    // one row of the directed table: an item (optionally with a typed-in result)
    // or a register write done while the block is idle
    typedef struct {
        t_row_kind           kind;
        logic                cmd;
        t_mode               mode;
        bit                  known;
        t_result             result;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
    } t_stim_row;

    // dut connections
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_cmd = CMD_TICK;
    logic [1:0]            i_new_mode = MODE_OFF;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_updated;
    logic                  o_red_write;
    logic                  o_green_write;
    logic                  o_blue_write;
    logic [DUTY_W-1:0]     o_red_duty;
    logic [DUTY_W-1:0]     o_green_duty;
    logic [DUTY_W-1:0]     o_blue_duty;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = REG_INVERT_DUTY;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // shadow of the block: registers and pattern state
    t_cfg              shadow_cfg;
    t_mode             want_mode;      // last mode asked for
    t_mode             lit_mode;       // mode the last evaluation showed
    logic              blink_on;
    logic [MS_W-1:0]   ms_left;
    logic              parked;         // dark and holding, ticks do nothing
    logic [DUTY_W-1:0] pin_duty [3];   // red, green, blue as written to the pins

    t_result   pending_patterns [$];
    t_stim_row directed_rows [$];

    int unsigned pattern_errors = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;

    status_led_pattern_sequencer_top i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // pattern predictor
    // ------------------------------------------------------------------

    function automatic void reset_shadow();
        shadow_cfg = '{invert_duty: 1'b0, channel_enable: RST_CH_EN,
                       slow_half_ms: RST_SLOW_MS, fast_half_ms: RST_FAST_MS,
                       pulse_ms: RST_PULSE_MS};
        want_mode = MODE_OFF;
        lit_mode  = MODE_OFF;
        blink_on  = 1'b0;
        ms_left   = '0;
        parked    = 1'b1;
        for (int ch = 0; ch < 3; ch++)
            pin_duty[ch] = DUTY_DARK;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_INVERT_DUTY:    shadow_cfg.invert_duty    = data[0];
            REG_CHANNEL_ENABLE: shadow_cfg.channel_enable = data[2:0];
            REG_SLOW_HALF:      shadow_cfg.slow_half_ms   = data;
            REG_FAST_HALF:      shadow_cfg.fast_half_ms   = data;
            REG_PULSE_LENGTH:   shadow_cfg.pulse_ms       = data;
            default: ;  // spare indexes are dropped
        endcase
    endfunction

    // advances the shadow by one item and returns the result the block must give
    function automatic t_result next_pattern(input logic cmd, input t_mode mode);
        logic              reeval;
        logic [2:0]        wrote;
        logic [MS_W-1:0]   wait_ms;
        logic [DUTY_W-1:0] colour [3];
        reeval  = 1'b0;
        wrote   = '0;
        wait_ms = '0;
        for (int ch = 0; ch < 3; ch++)
            colour[ch] = DUTY_DARK;

        if (cmd == CMD_REQUEST) begin
            // a repeat of the mode already asked for changes nothing
            if (mode != want_mode) begin
                want_mode = mode;
                reeval    = 1'b1;
            end
        end else if (!parked) begin
            if (ms_left <= 1) begin
                ms_left = '0;
                reeval  = 1'b1;
            end else begin
                ms_left = ms_left - 1'b1;
            end
        end

        if (reeval) begin
            parked = 1'b0;
            case (want_mode)
                MODE_SEARCHING: begin
                    // phase carries over mode changes
                    blink_on = ~blink_on;
                    if (blink_on) begin
                        colour[0] = DUTY_FULL;
                        colour[1] = DUTY_AMBER;
                    end
                    wait_ms = shadow_cfg.slow_half_ms;
                end
                MODE_SENDING: begin
                    blink_on = ~blink_on;
                    if (blink_on)
                        colour[2] = DUTY_FULL;
                    wait_ms = shadow_cfg.fast_half_ms;
                end
                default: begin
                    // green pulse only on a fresh join, otherwise dark and hold
                    if (want_mode == MODE_CONNECTED && lit_mode != MODE_CONNECTED
                            && lit_mode != MODE_SENDING) begin
                        colour[1] = DUTY_FULL;
                        wait_ms   = shadow_cfg.pulse_ms;
                    end else begin
                        parked = 1'b1;
                    end
                end
            endcase
            // a zero length runs as one millisecond
            if (parked)
                ms_left = '0;
            else
                ms_left = (wait_ms == '0) ? MS_W'(1) : wait_ms;
            // absent channels keep their old duty
            for (int ch = 0; ch < 3; ch++) begin
                if (shadow_cfg.channel_enable[ch]) begin
                    pin_duty[ch] = shadow_cfg.invert_duty ? ~colour[ch] : colour[ch];
                    wrote[ch]    = 1'b1;
                end
            end
            lit_mode = want_mode;
        end

        return '{reeval, wrote[0], wrote[1], wrote[2], pin_duty[0], pin_duty[1], pin_duty[2]};
    endfunction

    // ------------------------------------------------------------------
    // directed table builders
    // ------------------------------------------------------------------

    function automatic void add_item(input logic cmd, input t_mode mode);
        directed_rows.push_back('{ROW_ITEM, cmd, mode, 1'b0, '0, '0, '0});
    endfunction

    function automatic void add_known(input logic cmd, input t_mode mode, input t_result res);
        directed_rows.push_back('{ROW_ITEM, cmd, mode, 1'b1, res, '0, '0});
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        directed_rows.push_back('{ROW_REG, CMD_TICK, MODE_OFF, 1'b0, '0, idx, data});
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // presents one item after a random gap and books its expected result on acceptance;
    // valid stays high across back-to-back items and through a stall
    task automatic send_item(input logic cmd, input t_mode mode,
                             input bit known, input t_result known_res);
        t_result predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
        i_in_valid  <= 1'b1;
        i_cmd       <= cmd;
        i_new_mode  <= mode;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predicted = next_pattern(cmd, mode);
        pending_patterns.push_back(known ? known_res : predicted);
    endtask

    // lets every booked result come out so the block is idle for a register write
    task automatic drain_items();
        i_in_valid <= 1'b0;
        while (pending_patterns.size() != 0)
            @(posedge i_clk);
    endtask

    // write enable is left high so back-to-back writes need no toggle;
    // the next item lowers it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
    endtask

    // ------------------------------------------------------------------
    // result side: random stall and scoreboard
    // ------------------------------------------------------------------

    function automatic void cmp_field(input string name, input int unsigned want,
                                      input int unsigned got);
        if (want != got) begin
            pattern_errors++;
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : result_sink
        t_result got;
        t_result want;
        got = '{o_updated, o_red_write, o_green_write, o_blue_write,
                o_red_duty, o_green_duty, o_blue_duty};
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_patterns.size() == 0) begin
                pattern_errors++;
                $display("%0t ns: result with nothing expected, expected none actual %h",
                         $time, got);
            end else begin
                want = pending_patterns.pop_front();
                cmp_field("updated",     want.updated,     got.updated);
                cmp_field("red_write",   want.red_write,   got.red_write);
                cmp_field("green_write", want.green_write, got.green_write);
                cmp_field("blue_write",  want.blue_write,  got.blue_write);
                cmp_field("red_duty",    want.red_duty,    got.red_duty);
                cmp_field("green_duty",  want.green_duty,  got.green_duty);
                cmp_field("blue_duty",   want.blue_duty,   got.blue_duty);
            end
        end
        i_out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // hang detector: any handshake or register write counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || i_cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $time, quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    initial begin
        t_stim_row             row;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  cmd;
        reset_shadow();

        // after reset: held dark, ticks and a repeat of off change nothing
        add_known(CMD_TICK,    MODE_OFF,       '{1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0});
        add_known(CMD_REQUEST, MODE_OFF,       '{1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0});
        // amber on, then a tick that only counts down (mode bits set but unused)
        add_known(CMD_REQUEST, MODE_SEARCHING, '{1'b1, 1'b1, 1'b1, 1'b1, 8'd255, 8'd64, 8'd0});
        add_item(CMD_TICK, MODE_CONNECTED);
        // sending picks up the phase left by searching, so it starts dark
        add_known(CMD_REQUEST, MODE_SENDING,   '{1'b1, 1'b1, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0});
        add_known(CMD_REQUEST, MODE_SENDING,   '{1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0});
        // connected straight after sending is no fresh join: dark
        add_known(CMD_REQUEST, MODE_CONNECTED, '{1'b1, 1'b1, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0});
        add_known(CMD_REQUEST, MODE_OFF,       '{1'b1, 1'b1, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0});
        // zero pulse length runs as one millisecond
        add_reg(REG_PULSE_LENGTH, 16'd0);
        add_known(CMD_REQUEST, MODE_CONNECTED, '{1'b1, 1'b1, 1'b1, 1'b1, 8'd0, 8'd255, 8'd0});
        add_known(CMD_TICK,    MODE_OFF,       '{1'b1, 1'b1, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0});
        add_known(CMD_TICK,    MODE_OFF,       '{1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0});
        // inverted polarity on every write; shortest slow period
        add_reg(REG_SLOW_HALF, 16'd1);
        add_reg(REG_INVERT_DUTY, 16'd1);
        add_known(CMD_REQUEST, MODE_SEARCHING, '{1'b1, 1'b1, 1'b1, 1'b1, 8'd0, 8'd191, 8'd255});
        add_known(CMD_TICK,    MODE_SEARCHING, '{1'b1, 1'b1, 1'b1, 1'b1, 8'd255, 8'd255, 8'd255});
        // green only, polarity back to normal: red and blue keep their inverted duties
        add_reg(REG_CHANNEL_ENABLE, 16'h0002);
        add_reg(REG_FAST_HALF, 16'hFFFF);
        add_reg(REG_INVERT_DUTY, 16'd0);
        add_known(CMD_REQUEST, MODE_SENDING,   '{1'b1, 1'b0, 1'b1, 1'b0, 8'd255, 8'd0, 8'd255});
        add_item(CMD_TICK, MODE_SENDING);
        // spare indexes are dropped; no channel present means no strobes at all
        add_reg(REG_IDX_SPARE_LO, 16'hFFFF);
        add_reg(REG_IDX_SPARE_HI, 16'h0000);
        add_reg(REG_CHANNEL_ENABLE, 16'h0000);
        add_known(CMD_REQUEST, MODE_SEARCHING, '{1'b1, 1'b0, 1'b0, 1'b0, 8'd255, 8'd0, 8'd255});
        // all ones in every register; upper data bits must be ignored
        add_reg(REG_CHANNEL_ENABLE, 16'hFFFF);
        add_reg(REG_SLOW_HALF, 16'hFFFF);
        add_reg(REG_PULSE_LENGTH, 16'hFFFF);
        add_reg(REG_INVERT_DUTY, 16'hFFFF);
        add_known(CMD_REQUEST, MODE_CONNECTED, '{1'b1, 1'b1, 1'b1, 1'b1, 8'd255, 8'd0, 8'd255});
        add_item(CMD_TICK, MODE_OFF);
        add_item(CMD_REQUEST, MODE_OFF);
        // zero fast period: the blink flips on every tick
        add_reg(REG_FAST_HALF, 16'd0);
        add_item(CMD_REQUEST, MODE_SENDING);
        add_item(CMD_TICK, MODE_SENDING);
        add_item(CMD_TICK, MODE_SENDING);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct   = 31;
        sink_stall_pct = 46;
        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.kind == ROW_REG) begin
                drain_items();
                write_reg(row.reg_idx, row.reg_data);
            end else begin
                send_item(row.cmd, row.mode, row.known, row.result);
            end
        end

        // random part: three idling profiles, each split into blocks that start with
        // a few register writes on an idle block; short periods keep blinks moving
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin src_idle_pct = 31; sink_stall_pct = 46; end
                1:       begin src_idle_pct = 46; sink_stall_pct = 31; end
                default: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            endcase
            for (int blk = 0; blk < 6; blk++) begin
                drain_items();
                repeat ($urandom_range(1, 4)) begin
                    idx = CFG_IDX_W'($urandom_range(7));
                    if (idx == REG_SLOW_HALF || idx == REG_FAST_HALF
                            || idx == REG_PULSE_LENGTH) begin
                        case ($urandom_range(9))
                            0:       data = '0;
                            1:       data = '1;
                            2:       data = CFG_DATA_W'($urandom);
                            default: data = CFG_DATA_W'($urandom_range(1, 5));
                        endcase
                    end else begin
                        data = CFG_DATA_W'($urandom);
                    end
                    write_reg(idx, data);
                end
                // mostly ticks so that waits run out, requests spread over all modes
                repeat (22) begin
                    cmd = ($urandom_range(99) < 25) ? CMD_REQUEST : CMD_TICK;
                    send_item(cmd, t_mode'($urandom_range(3)), 1'b0, '0);
                end
            end
        end

        drain_items();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pattern_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== status_led_pattern_sequencer_top.f =====
sv/slps_pkg.sv
sv/slps_cfg.sv
sv/slps_core.sv
sv/status_led_pattern_sequencer_top.sv
bench/status_led_pattern_sequencer_top_tb.sv
